// ===== rtl/core/brbm_pkg.sv =====
// ----------------------------------------------------------------------------
// brbm_pkg
// Shared types, constants and helpers of the box redact / blend / mosaic core.
// ----------------------------------------------------------------------------
`default_nettype none

package brbm_pkg;

  // field widths
  localparam int COORD_W    = 12;
  localparam int SAMPLE_W   = 8;
  localparam int EDGE_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SUM_W      = 16;

  // parameter defaults
  localparam int BLOCK_SIZE_DEF = 64;
  localparam int MAX_WIDTH_DEF  = 4096;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEFT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_RIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_TOP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_BOTTOM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REDACT_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_YUVA   = 3'd5;

  // redact mode codes
  localparam logic MODE_SOLID  = 1'b0;
  localparam logic MODE_MOSAIC = 1'b1;

  // one pixel, three samples
  typedef struct packed {
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] cb;
    logic [SAMPLE_W-1:0] cr;
  } pix_t;

  // floor(s / 255) for s <= 255*255: estimate s>>8 is low by at most one,
  // the remainder (s mod 256) + estimate tells whether to bump it
  function automatic logic [SAMPLE_W-1:0] div255(input logic [SUM_W-1:0] s);
    logic [SAMPLE_W-1:0] q0;
    logic [SAMPLE_W:0]   r;
    q0 = s[SUM_W-1:SAMPLE_W];
    r  = {1'b0, s[SAMPLE_W-1:0]} + {1'b0, q0};
    if (r >= 9'd255) begin
      div255 = q0 + 8'd1;
    end else begin
      div255 = q0;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/brbm_corner_store.sv =====
// ----------------------------------------------------------------------------
// brbm_corner_store
// Per block column store of corner pixels, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module brbm_corner_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire brbm_pkg::pix_t wdata_i,
  output brbm_pkg::pix_t     rdata_o
);
  import brbm_pkg::*;

  pix_t mem [DEPTH];
  pix_t rdata_q;

  // write port, read-before-write on a shared address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/box_redact_blend_mosaic_core.sv =====
// ----------------------------------------------------------------------------
// box_redact_blend_mosaic_core
// Box privacy mask on a 4:4:4 pixel stream: solid blend or block mosaic.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle when not stalled; four stages (block index,
// corner store read, blend products, divide and select) each hold one word.
// Reset: clears stage valids and loads the register reset values; the corner
// store is not cleared and each entry is defined once its corner was seen.
`default_nettype none

module box_redact_blend_mosaic_core #(
  parameter int BLOCK_SIZE = brbm_pkg::BLOCK_SIZE_DEF,
  parameter int MAX_WIDTH  = brbm_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [brbm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [brbm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // pixel input
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [brbm_pkg::COORD_W-1:0]     col_i,
  input  wire logic [brbm_pkg::COORD_W-1:0]     row_index_i,
  input  wire logic [brbm_pkg::SAMPLE_W-1:0]    luma_in_i,
  input  wire logic [brbm_pkg::SAMPLE_W-1:0]    cb_in_i,
  input  wire logic [brbm_pkg::SAMPLE_W-1:0]    cr_in_i,
  // pixel output
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [brbm_pkg::SAMPLE_W-1:0]         luma_out_o,
  output logic [brbm_pkg::SAMPLE_W-1:0]         cb_out_o,
  output logic [brbm_pkg::SAMPLE_W-1:0]         cr_out_o
);
  import brbm_pkg::*;

  localparam int StoreDepth = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int StoreAw    = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  // exact reciprocal for coordinate / BLOCK_SIZE
  localparam int DivShift   = COORD_W + $clog2(BLOCK_SIZE);
  localparam int ProdW      = DivShift + COORD_W;
  localparam logic [ProdW-1:0] RecipM =
      ProdW'(((64'd1 << DivShift) + BLOCK_SIZE - 1) / BLOCK_SIZE);
  localparam logic [ProdW-1:0] BlockK = ProdW'(BLOCK_SIZE);
  localparam logic [COORD_W:0] DepthK = (COORD_W + 1)'(StoreDepth);

  // configuration registers
  logic [COORD_W-1:0]    box_left_q, box_top_q;
  logic [EDGE_W-1:0]     box_right_q, box_bottom_q;
  logic                  mode_q;
  logic [CFG_DATA_W-1:0] fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_left_q   <= '0;
      box_right_q  <= '0;
      box_top_q    <= '0;
      box_bottom_q <= '0;
      mode_q       <= MODE_MOSAIC;
      fill_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BOX_LEFT:    box_left_q   <= cfg_data_i[COORD_W-1:0];
        CFG_BOX_RIGHT:   box_right_q  <= cfg_data_i[EDGE_W-1:0];
        CFG_BOX_TOP:     box_top_q    <= cfg_data_i[COORD_W-1:0];
        CFG_BOX_BOTTOM:  box_bottom_q <= cfg_data_i[EDGE_W-1:0];
        CFG_REDACT_MODE: mode_q       <= cfg_data_i[0];
        CFG_FILL_YUVA:   fill_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage enables, a stage moves when the next one is empty or moving
  logic va_q, vb_q, vc_q, vd_q;
  logic en_a, en_b, en_c, en_d;

  assign en_d       = !vd_q || !out_stall_i;
  assign en_c       = !vc_q || en_d;
  assign en_b       = !vb_q || en_c;
  assign en_a       = !va_q || en_b;
  assign in_stall_o = !en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
      if (en_d) vd_q <= vc_q;
    end
  end

  // stage a: block index and box test
  logic [ProdW-1:0]   col_prod, row_prod;
  logic               inside_d;
  logic [COORD_W-1:0] col_a_q, row_a_q, bcol_a_q, brow_a_q;
  pix_t               pix_a_q;
  logic               inside_a_q;

  assign col_prod = ProdW'(col_i) * RecipM;
  assign row_prod = ProdW'(row_index_i) * RecipM;
  assign inside_d = (col_i >= box_left_q) && ({1'b0, col_i} < box_right_q) &&
                    (row_index_i >= box_top_q) && ({1'b0, row_index_i} < box_bottom_q);

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      col_a_q    <= col_i;
      row_a_q    <= row_index_i;
      bcol_a_q   <= col_prod[DivShift +: COORD_W];
      brow_a_q   <= row_prod[DivShift +: COORD_W];
      pix_a_q    <= '{y: luma_in_i, cb: cb_in_i, cr: cr_in_i};
      inside_a_q <= inside_d;
    end
  end

  // corner detection and store access
  logic has_entry_a, corner_a, store_we;
  pix_t store_rdata;

  assign has_entry_a = {1'b0, bcol_a_q} < DepthK;
  assign corner_a    = has_entry_a &&
                       ((ProdW'(bcol_a_q) * BlockK) == ProdW'(col_a_q)) &&
                       ((ProdW'(brow_a_q) * BlockK) == ProdW'(row_a_q));
  assign store_we    = va_q && en_b && corner_a;

  brbm_corner_store #(
    .DEPTH (StoreDepth),
    .AW    (StoreAw)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .re_i    (en_b),
    .addr_i  (bcol_a_q[StoreAw-1:0]),
    .wdata_i (pix_a_q),
    .rdata_o (store_rdata)
  );

  // stage b: store data arrives
  pix_t pix_b_q;
  logic inside_b_q, corner_b_q, has_entry_b_q;

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      pix_b_q       <= pix_a_q;
      inside_b_q    <= inside_a_q;
      corner_b_q    <= corner_a;
      has_entry_b_q <= has_entry_a;
    end
  end

  // stage c: blend products, mosaic pick with own-corner bypass
  logic [SAMPLE_W-1:0] alpha, alpha_inv;
  logic [SUM_W-1:0]    sum_y_c_q, sum_cb_c_q, sum_cr_c_q;
  pix_t                pix_c_q, mos_c_q;
  logic                blend_c_q, mosaic_c_q;

  assign alpha     = fill_q[7:0];
  assign alpha_inv = 8'd255 - alpha;

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      sum_y_c_q  <= SUM_W'(pix_b_q.y)  * SUM_W'(alpha_inv) + SUM_W'(fill_q[31:24]) * SUM_W'(alpha);
      sum_cb_c_q <= SUM_W'(pix_b_q.cb) * SUM_W'(alpha_inv) + SUM_W'(fill_q[23:16]) * SUM_W'(alpha);
      sum_cr_c_q <= SUM_W'(pix_b_q.cr) * SUM_W'(alpha_inv) + SUM_W'(fill_q[15:8])  * SUM_W'(alpha);
      pix_c_q    <= pix_b_q;
      mos_c_q    <= corner_b_q ? pix_b_q : store_rdata;
      blend_c_q  <= inside_b_q && (mode_q == MODE_SOLID);
      mosaic_c_q <= inside_b_q && (mode_q == MODE_MOSAIC) && has_entry_b_q;
    end
  end

  // stage d: divide by 255 and select into the output register
  logic [SAMPLE_W-1:0] y_q, cb_q, cr_q;

  always_ff @(posedge clk_i) begin
    if (en_d) begin
      if (blend_c_q) begin
        y_q  <= div255(sum_y_c_q);
        cb_q <= div255(sum_cb_c_q);
        cr_q <= div255(sum_cr_c_q);
      end else if (mosaic_c_q) begin
        y_q  <= mos_c_q.y;
        cb_q <= mos_c_q.cb;
        cr_q <= mos_c_q.cr;
      end else begin
        y_q  <= pix_c_q.y;
        cb_q <= pix_c_q.cb;
        cr_q <= pix_c_q.cr;
      end
    end
  end

  assign out_valid_o = vd_q;
  assign luma_out_o  = y_q;
  assign cb_out_o    = cb_q;
  assign cr_out_o    = cr_q;

`ifndef SYNTHESIS
  // input stalls only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (va_q && vb_q && vc_q && vd_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // an accepted word lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> va_q)
    else $error("accepted word lost at pipeline entry");

  // output drains when nothing follows
  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !vc_q) |=> !out_valid_o)
    else $error("result repeated on the output");

  // blend and mosaic selects never both set
  a_sel_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q |-> !(blend_c_q && mosaic_c_q))
    else $error("blend and mosaic selected together");
`endif

endmodule

`default_nettype wire

// ===== verif/box_redact_blend_mosaic_core_tb.sv =====
// ----------------------------------------------------------------------------
// box_redact_blend_mosaic_core_tb
// Self-checking bench for the box privacy mask: pixels go in with their
// coordinates, a local predictor of blend, mosaic and pass-through works out
// each expected word, and every output word is compared field by field.
// Directed cases come first, then random raster scans under random configs
// with random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module box_redact_blend_mosaic_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brbm_pkg::*;

  localparam int BLOCK       = BLOCK_SIZE_DEF;
  localparam int FRAME_MAX   = MAX_WIDTH_DEF;
  localparam int DEPTH       = (FRAME_MAX + BLOCK - 1) / BLOCK;
  localparam int LATENCY     = 4;
  localparam int SETTLE      = 2 * LATENCY;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_GAP     = 20;

  // dut ports
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  wire logic             in_stall_o;
  logic [COORD_W-1:0]    col_i       = '0;
  logic [COORD_W-1:0]    row_index_i = '0;
  logic [SAMPLE_W-1:0]   luma_in_i   = '0;
  logic [SAMPLE_W-1:0]   cb_in_i     = '0;
  logic [SAMPLE_W-1:0]   cr_in_i     = '0;
  wire logic             out_valid_o;
  logic                  out_stall_i = 1'b0;
  wire logic [SAMPLE_W-1:0] luma_out_o;
  wire logic [SAMPLE_W-1:0] cb_out_o;
  wire logic [SAMPLE_W-1:0] cr_out_o;

  // shadow registers, reset values of the block
  logic [COORD_W-1:0]    left_q   = '0;
  logic [EDGE_W-1:0]     right_q  = '0;
  logic [COORD_W-1:0]    top_q    = '0;
  logic [EDGE_W-1:0]     bottom_q = '0;
  logic                  mode_q   = MODE_MOSAIC;
  logic [CFG_DATA_W-1:0] fill_q   = '0;

  // shadow corner store and which entries were written
  pix_t             corner_mem [DEPTH];
  logic [DEPTH-1:0] corner_seen = '0;

  pix_t expected_pix [$];
  int   errors         = 0;
  int   send_idle_pct  = 10;
  int   recv_idle_pct  = 75;
  int   hold_req       = 0;
  int   hold_left      = 0;
  int   quiet_cycles   = 0;

  box_redact_blend_mosaic_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .col_i       (col_i),
    .row_index_i (row_index_i),
    .luma_in_i   (luma_in_i),
    .cb_in_i     (cb_in_i),
    .cr_in_i     (cr_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .luma_out_o  (luma_out_o),
    .cb_out_o    (cb_out_o),
    .cr_out_o    (cr_out_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // box membership under the current shadow config
  function automatic bit in_box(int c, int r);
    return c >= left_q && c < right_q && r >= top_q && r < bottom_q;
  endfunction

  // one component toward the fill colour, truncated
  function automatic logic [SAMPLE_W-1:0] blend(logic [SAMPLE_W-1:0] p,
                                                logic [SAMPLE_W-1:0] c,
                                                logic [SAMPLE_W-1:0] a);
    int s;
    s = int'(p) * (255 - int'(a)) + int'(c) * int'(a);
    return SAMPLE_W'(s / 255);
  endfunction

  // random sample value
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    return SAMPLE_W'($urandom_range(255));
  endfunction

  // expected output word; corner pixels update the shadow store first
  function automatic pix_t redact_pixel(int c, int r, pix_t p);
    int   bc;
    pix_t o;
    bc = c / BLOCK;
    o  = p;
    if (bc < DEPTH && c % BLOCK == 0 && r % BLOCK == 0) begin
      corner_mem[bc]  = p;
      corner_seen[bc] = 1'b1;
    end
    if (in_box(c, r)) begin
      if (mode_q == MODE_SOLID) begin
        o.y  = blend(p.y,  fill_q[31:24], fill_q[7:0]);
        o.cb = blend(p.cb, fill_q[23:16], fill_q[7:0]);
        o.cr = blend(p.cr, fill_q[15:8],  fill_q[7:0]);
      end else if (bc < DEPTH) begin
        o = corner_mem[bc];
      end
    end
    return o;
  endfunction

  // offer one pixel word, hold it until taken, then record its expectation
  task automatic send_pixel(int c, int r, logic [SAMPLE_W-1:0] y,
                            logic [SAMPLE_W-1:0] cb, logic [SAMPLE_W-1:0] cr);
    int   gap;
    int   cc;
    int   rr;
    pix_t p;
    cc = c;
    rr = r;
    // a mosaic read of a block whose corner was never seen becomes that corner
    if (mode_q == MODE_MOSAIC && in_box(cc, rr) && cc / BLOCK < DEPTH &&
        !corner_seen[cc / BLOCK]) begin
      cc = cc - cc % BLOCK;
      rr = rr - rr % BLOCK;
    end
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    col_i       <= COORD_W'(cc);
    row_index_i <= COORD_W'(rr);
    luma_in_i   <= y;
    cb_in_i     <= cb;
    cr_in_i     <= cr;
    do @(posedge clk_i); while (in_stall_o);
    p = {y, cb, cr};
    expected_pix.push_back(redact_pixel(cc, rr, p));
  endtask

  // let the pipe drain before touching registers
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_pix.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
  endtask

  // write every register while idle and mirror it
  task automatic set_config(int l, int rt, int t, int b, logic m,
                            logic [CFG_DATA_W-1:0] f);
    wait_idle();
    write_reg(CFG_BOX_LEFT,    CFG_DATA_W'(l));
    write_reg(CFG_BOX_RIGHT,   CFG_DATA_W'(rt));
    write_reg(CFG_BOX_TOP,     CFG_DATA_W'(t));
    write_reg(CFG_BOX_BOTTOM,  CFG_DATA_W'(b));
    write_reg(CFG_REDACT_MODE, CFG_DATA_W'(m));
    write_reg(CFG_FILL_YUVA,   f);
    cfg_we_i <= 1'b0;
    left_q   = COORD_W'(l);
    right_q  = EDGE_W'(rt);
    top_q    = COORD_W'(t);
    bottom_q = EDGE_W'(b);
    mode_q   = m;
    fill_q   = f;
  endtask

  // block index biased toward the frame edges
  function automatic int pick_block();
    int v;
    v = $urandom_range(9);
    if (v == 0) return 0;
    if (v == 1) return DEPTH - 1;
    return $urandom_range(DEPTH - 1);
  endfunction

  // receiver: random stall, or a counted hold-off when requested
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // compare each output word with the oldest expectation
  always @(posedge clk_i) begin : check_results
    pix_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_pix.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none actual %h %h %h",
                 $time, luma_out_o, cb_out_o, cr_out_o);
      end else begin
        want = expected_pix.pop_front();
        if (luma_out_o !== want.y) begin
          errors++;
          $display("%0t: luma mismatch, expected %h actual %h",
                   $time, want.y, luma_out_o);
        end
        if (cb_out_o !== want.cb) begin
          errors++;
          $display("%0t: cb mismatch, expected %h actual %h",
                   $time, want.cb, cb_out_o);
        end
        if (cr_out_o !== want.cr) begin
          errors++;
          $display("%0t: cr mismatch, expected %h actual %h",
                   $time, want.cr, cr_out_o);
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // reset config: empty box, so everything passes; corner at origin written
  task automatic test_reset_passthrough();
    send_pixel(0, 0, 8'hab, 8'hcd, 8'hef);
    send_pixel(4095, 4095, 8'hff, 8'hff, 8'hff);
    send_pixel(2048, 1, 8'h00, 8'hff, 8'h00);
    send_pixel(63, 64, 8'h12, 8'h34, 8'h56);
  endtask

  // whole frame blended, alpha at zero, full and mid
  task automatic test_solid_blend();
    set_config(0, 4096, 0, 4096, MODE_SOLID, 32'hff00ff00);
    send_pixel(5, 5, 8'hff, 8'h00, 8'h80);
    set_config(0, 4096, 0, 4096, MODE_SOLID, 32'h10ff7fff);
    send_pixel(4095, 0, 8'h00, 8'hff, 8'h7f);
    send_pixel(0, 4095, 8'hff, 8'h00, 8'h01);
    set_config(0, 4096, 0, 4096, MODE_SOLID, 32'h80c04080);
    send_pixel(1, 2, 8'h00, 8'h00, 8'h00);
    send_pixel(3000, 17, 8'hff, 8'hff, 8'hff);
  endtask

  // mosaic box over three block columns, pixels in two of them, corners pass unchanged
  task automatic test_mosaic_blocks();
    set_config(64, 200, 64, 200, MODE_MOSAIC, 32'h11223344);
    send_pixel(64, 64, 8'h11, 8'h22, 8'h33);
    send_pixel(100, 64, 8'h99, 8'h88, 8'h77);
    send_pixel(127, 130, 8'h00, 8'hff, 8'h00);
    send_pixel(128, 128, 8'h44, 8'h55, 8'h66);
    send_pixel(130, 150, 8'hff, 8'h00, 8'hff);
    send_pixel(63, 100, 8'h5a, 8'ha5, 8'h3c);
  endtask

  // one-pixel box at the far corner, empty box, far-corner mosaic block
  task automatic test_box_edges();
    set_config(4095, 4096, 4095, 4096, MODE_SOLID, 32'h010203ff);
    send_pixel(4095, 4095, 8'h80, 8'h80, 8'h80);
    send_pixel(4094, 4095, 8'h80, 8'h80, 8'h80);
    send_pixel(4095, 4094, 8'h80, 8'h80, 8'h80);
    set_config(100, 100, 0, 4096, MODE_SOLID, 32'hffffffff);
    send_pixel(100, 5, 8'h42, 8'h43, 8'h44);
    set_config(4032, 4096, 4032, 4096, MODE_MOSAIC, 32'h0);
    send_pixel(4032, 4032, 8'hde, 8'had, 8'hbe);
    send_pixel(4095, 4095, 8'h01, 8'h02, 8'h03);
  endtask

  // output held off long enough to back up the input, then a full drain
  task automatic test_backpressure();
    int saved_send;
    int saved_recv;
    saved_send = send_idle_pct;
    saved_recv = recv_idle_pct;
    set_config(0, 4096, 0, 2048, MODE_SOLID, $urandom());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = HOLD_CYCLES;
    for (int c = 0; c < 60; c++) begin
      send_pixel(c, 2047 + c % 2, rand_sample(), rand_sample(), rand_sample());
    end
    wait_idle();
    send_idle_pct = saved_send;
    recv_idle_pct = saved_recv;
    for (int c = 0; c < 20; c++) begin
      send_pixel(4095 - c, 2047, rand_sample(), rand_sample(), rand_sample());
    end
  endtask

  // random config around one block, then raster scans and stray pixels
  task automatic run_region(int budget);
    int bx, by, l, rt, t, b, variant, sent, row, c0, w, rows;
    logic                  m;
    logic [CFG_DATA_W-1:0] f;
    bx = pick_block() * BLOCK;
    by = pick_block() * BLOCK;
    variant = $urandom_range(99);
    if (variant < 12) begin
      l = 0; rt = FRAME_MAX; t = 0; b = FRAME_MAX;
    end else if (variant < 22) begin
      l  = $urandom_range(4095);
      rt = $urandom_range(l);
      t  = $urandom_range(4095);
      b  = $urandom_range(4096);
    end else if (variant < 27) begin
      t  = $urandom_range(4095);
      b  = $urandom_range(t);
      l  = $urandom_range(4095);
      rt = $urandom_range(4096);
    end else begin
      l = bx - 20 + int'($urandom_range(100));
      if (l < 0) l = 0;
      if (l > 4095) l = 4095;
      rt = l + int'($urandom_range(130, 1));
      if (rt > FRAME_MAX) rt = FRAME_MAX;
      t = by - 20 + int'($urandom_range(100));
      if (t < 0) t = 0;
      if (t > 4095) t = 4095;
      b = t + int'($urandom_range(130, 1));
      if (b > FRAME_MAX) b = FRAME_MAX;
    end
    m = 1'($urandom_range(1));
    f = $urandom();
    case ($urandom_range(3))
      0: f[7:0] = 8'h00;
      1: f[7:0] = 8'hff;
      default: ;
    endcase
    set_config(l, rt, t, b, m, f);
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 15) begin
        // stray pixel anywhere in the frame
        send_pixel($urandom_range(4095), $urandom_range(4095), rand_sample(),
                   rand_sample(), rand_sample());
        sent++;
      end else begin
        // short raster scan, mostly from the block corner
        row  = ($urandom_range(4) == 0) ? by + int'($urandom_range(BLOCK - 1)) : by;
        c0   = ($urandom_range(4) == 0) ? bx + int'($urandom_range(BLOCK - 1)) : bx;
        w    = $urandom_range(96, 1);
        rows = $urandom_range(4, 1);
        for (int j = 0; j < rows && row < FRAME_MAX && sent < budget; j++) begin
          for (int c = c0; c < c0 + w && c < FRAME_MAX && sent < budget; c++) begin
            send_pixel(c, row, rand_sample(), rand_sample(), rand_sample());
            sent++;
          end
          row += $urandom_range(40, 1);
        end
      end
    end
  endtask

  // three idling phases of random regions
  task automatic test_random_regions();
    int n;
    int budget;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 10; recv_idle_pct = 75; end
        1: begin send_idle_pct = 75; recv_idle_pct = 10; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      n = 0;
      while (n < 385) begin
        budget = $urandom_range(140, 40);
        run_region(budget);
        n += budget;
      end
    end
  endtask

  // test sequence
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_passthrough();
    test_solid_blend();
    test_mosaic_blocks();
    test_box_edges();
    test_backpressure();
    test_random_regions();
    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
